/* sv/assert_macros.svh */
// Assertion macros shared by the rule table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define CHK_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/fmfw_pkg.sv */
// Package with the types, codes and helper functions of the firewall rule table.
package fmfw_pkg;

	localparam int MAX_RULES_DEF = 32;

	localparam logic [2:0] OP_LOOKUP   = 3'd0;
	localparam logic [2:0] OP_ADD_HEAD = 3'd1;
	localparam logic [2:0] OP_ADD_TAIL = 3'd2;
	localparam logic [2:0] OP_DELETE   = 3'd3;
	localparam logic [2:0] OP_TICK     = 3'd4;

	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_FULL  = 2'd1;
	localparam logic [1:0] STS_RANGE = 2'd2;

	localparam logic [1:0] REG_DEF_IN  = 2'd0;
	localparam logic [1:0] REG_DEF_OUT = 2'd1;
	localparam logic [1:0] REG_TIMEOUT = 2'd2;

	localparam logic [15:0] TIMEOUT_RST = 16'd60;
	localparam logic [5:0]  PFX_MAX     = 6'd32;

	typedef struct packed {
		logic        session;
		logic [3:0]  iface;
		logic        direction;
		logic [2:0]  protocol;
		logic [5:0]  src_prefix;
		logic [5:0]  dst_prefix;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [1:0]  action;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [31:0] hits;
		logic [31:0] last_seen;
	} rule_t;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [4:0]  index;
		logic [3:0]  iface;
		logic        direction;
		logic [2:0]  protocol;
		logic [31:0] src_ip;
		logic [5:0]  src_prefix;
		logic [15:0] src_port;
		logic [31:0] dst_ip;
		logic [5:0]  dst_prefix;
		logic [15:0] dst_port;
		logic [1:0]  rule_action;
	} req_t;

	typedef struct packed {
		logic hit;
		logic expired;
	} eval_t;

	function automatic logic [31:0] prefix_mask(input logic [5:0] p);
		logic [31:0] m;
		if (p == 6'd0) begin
			m = 32'd0;
		end else if (p >= PFX_MAX) begin
			m = 32'hFFFF_FFFF;
		end else begin
			m = ~(32'hFFFF_FFFF >> p);
		end
		return m;
	endfunction

endpackage

/* sv/fmfw_ram.sv */
// Generic single write port RAM with one registered read port.
module fmfw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* sv/fmfw_eval.sv */
// Compare unit that checks one stored rule against the request and its idle time.
module fmfw_eval import fmfw_pkg::*; (
	input  rule_t       rule,
	input  req_t        req,
	input  logic [31:0] now,
	input  logic [15:0] timeout,
	output eval_t       result
);

	logic [31:0] ms;
	logic [31:0] md;
	logic [31:0] age;

	always_comb begin
		ms  = prefix_mask(rule.src_prefix);
		md  = prefix_mask(rule.dst_prefix);
		age = now - rule.last_seen;
		result.hit = (rule.iface != 4'd0) && (rule.iface == req.iface) &&
			(rule.direction == req.direction) && (rule.protocol == req.protocol) &&
			((rule.src_ip & ms) == (req.src_ip & ms)) &&
			((rule.dst_ip & md) == (req.dst_ip & md)) &&
			((rule.src_port == 16'd0) || (rule.src_port == req.src_port)) &&
			((rule.dst_port == 16'd0) || (rule.dst_port == req.dst_port));
		result.expired = rule.session && (age >= {16'd0, timeout});
	end

endmodule

/* sv/first_match_firewall_rule_table_core.sv */
// A lookup walks the table until the first hit or its end; a head add or a delete or a tick
// walks the table with one RAM read each cycle.
// A tail add, a rejected request and an unused opcode give their result in the cycle after they are accepted.
// Throughput: one request at a time; busy stays high while the rule RAM is walked.
// The result strobe done lasts one cycle and cannot be stalled by the receiver.
// Reset clears the rule count, the tick counter, the pointers and the outputs; rule contents need none.
module first_match_firewall_rule_table_core import fmfw_pkg::*; #(
	parameter int MAX_RULES = MAX_RULES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  opcode,
	input  logic [4:0]  index,
	input  logic [3:0]  iface,
	input  logic        direction,
	input  logic [2:0]  protocol,
	input  logic [31:0] src_ip,
	input  logic [5:0]  src_prefix,
	input  logic [15:0] src_port,
	input  logic [31:0] dst_ip,
	input  logic [5:0]  dst_prefix,
	input  logic [15:0] dst_port,
	input  logic [1:0]  rule_action,
	output logic        done,
	output logic [1:0]  verdict,
	output logic        matched,
	output logic [4:0]  rule_position,
	output logic [31:0] hit_total,
	output logic [1:0]  status,
	output logic [5:0]  occupancy,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	`include "assert_macros.svh"

	localparam int AW = $clog2(MAX_RULES);
	localparam int CW = $clog2(MAX_RULES + 1);
	localparam int RW = $bits(rule_t);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_SWEEP
	} state_t;

	state_t         state_q;
	req_t           req_q;
	req_t           req_d;
	logic [CW-1:0]  total_q;
	logic [CW-1:0]  rd_ptr_q;
	logic [CW-1:0]  wr_ptr_q;
	logic [CW-1:0]  rd_dec;
	logic           vld_s1;
	logic [AW-1:0]  pos_s1;
	logic [31:0]    now_q;
	logic [1:0]     def_in_q;
	logic [1:0]     def_out_q;
	logic [15:0]    timeout_q;
	logic           accept;
	logic           full;
	logic           issue;
	logic           ram_we;
	logic [AW-1:0]  ram_waddr;
	logic [AW-1:0]  ram_raddr;
	rule_t          ram_wdata;
	rule_t          rdata;
	logic [RW-1:0]  rdata_raw;
	eval_t          ev;
	logic           drop;
	logic [31:0]    hits_new;
	logic           cfg_wr;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign full   = (32'(total_q) >= 32'(MAX_RULES));
	assign rd_dec = rd_ptr_q - CW'(1);
	assign rdata  = rule_t'(rdata_raw);
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		req_d.opcode      = opcode;
		req_d.index       = index;
		req_d.iface       = iface;
		req_d.direction   = direction;
		req_d.protocol    = protocol;
		req_d.src_ip      = src_ip;
		req_d.src_prefix  = (src_prefix > PFX_MAX) ? PFX_MAX : src_prefix;
		req_d.src_port    = src_port;
		req_d.dst_ip      = dst_ip;
		req_d.dst_prefix  = (dst_prefix > PFX_MAX) ? PFX_MAX : dst_prefix;
		req_d.dst_port    = dst_port;
		req_d.rule_action = rule_action;
	end

	function automatic rule_t make_rule(input req_t r, input logic sess, input logic [31:0] t);
		rule_t n;
		n.session    = sess;
		n.iface      = r.iface;
		n.direction  = r.direction;
		n.protocol   = r.protocol;
		n.src_prefix = r.src_prefix;
		n.dst_prefix = r.dst_prefix;
		n.src_port   = r.src_port;
		n.dst_port   = r.dst_port;
		n.action     = r.rule_action;
		n.src_ip     = r.src_ip;
		n.dst_ip     = r.dst_ip;
		n.hits       = 32'd0;
		n.last_seen  = t;
		return n;
	endfunction

	fmfw_eval u_eval (
		.rule    (rdata),
		.req     (req_q),
		.now     (now_q),
		.timeout (timeout_q),
		.result  (ev)
	);

	assign drop = (req_q.opcode == OP_DELETE) ? (32'(pos_s1) == 32'(req_q.index)) : ev.expired;
	assign hits_new = (rdata.hits == 32'hFFFF_FFFF) ? rdata.hits : rdata.hits + 32'd1;

	always_comb begin
		case (state_q)
			ST_SCAN, ST_SWEEP: issue = (rd_ptr_q < total_q);
			ST_SHIFT:          issue = (rd_ptr_q != CW'(0));
			default:           issue = 1'b0;
		endcase
		ram_raddr = (state_q == ST_SHIFT) ? rd_dec[AW-1:0] : rd_ptr_q[AW-1:0];
		ram_we    = 1'b0;
		ram_waddr = total_q[AW-1:0];
		ram_wdata = rdata;
		case (state_q)
			ST_IDLE: begin
				ram_we    = accept && (opcode == OP_ADD_TAIL) && !full;
				ram_wdata = make_rule(req_d, 1'b0, 32'd0);
			end
			ST_SCAN: begin
				ram_we    = vld_s1 && ev.hit;
				ram_waddr = pos_s1;
				ram_wdata.hits      = hits_new;
				ram_wdata.last_seen = now_q;
			end
			ST_SHIFT: begin
				if (vld_s1) begin
					ram_we    = 1'b1;
					ram_waddr = pos_s1 + AW'(1);
				end else if (rd_ptr_q == CW'(0)) begin
					ram_we    = 1'b1;
					ram_waddr = AW'(0);
					ram_wdata = make_rule(req_q, 1'b1, now_q);
				end
			end
			ST_SWEEP: begin
				ram_we    = vld_s1 && !drop;
				ram_waddr = wr_ptr_q[AW-1:0];
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	fmfw_ram #(
		.WIDTH (RW),
		.DEPTH (MAX_RULES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (issue),
		.raddr (ram_raddr),
		.rdata (rdata_raw)
	);

	always_comb begin
		case (paddr[3:2])
			REG_DEF_IN:  prdata = {30'd0, def_in_q};
			REG_DEF_OUT: prdata = {30'd0, def_out_q};
			REG_TIMEOUT: prdata = {16'd0, timeout_q};
			default:     prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			def_in_q  <= 2'd0;
			def_out_q <= 2'd0;
			timeout_q <= TIMEOUT_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_DEF_IN:  def_in_q  <= pwdata[1:0];
				REG_DEF_OUT: def_out_q <= pwdata[1:0];
				REG_TIMEOUT: timeout_q <= pwdata[15:0];
				default:     def_in_q  <= def_in_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_d;
		end
		pos_s1 <= ram_raddr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			total_q       <= '0;
			rd_ptr_q      <= '0;
			wr_ptr_q      <= '0;
			vld_s1        <= 1'b0;
			now_q         <= 32'd0;
			done          <= 1'b0;
			verdict       <= 2'd0;
			matched       <= 1'b0;
			rule_position <= 5'd0;
			hit_total     <= 32'd0;
			status        <= STS_OK;
			occupancy     <= 6'd0;
		end else begin
			done   <= 1'b0;
			vld_s1 <= issue;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						rd_ptr_q      <= '0;
						wr_ptr_q      <= '0;
						verdict       <= 2'd0;
						matched       <= 1'b0;
						rule_position <= 5'd0;
						hit_total     <= 32'd0;
						status        <= STS_OK;
						occupancy     <= 6'(total_q);
						case (opcode)
							OP_LOOKUP: begin
								state_q <= ST_SCAN;
							end
							OP_ADD_HEAD: begin
								if (full) begin
									status <= STS_FULL;
									done   <= 1'b1;
								end else begin
									rd_ptr_q <= total_q;
									state_q  <= ST_SHIFT;
								end
							end
							OP_ADD_TAIL: begin
								if (full) begin
									status <= STS_FULL;
								end else begin
									total_q   <= total_q + CW'(1);
									occupancy <= 6'(total_q + CW'(1));
								end
								done <= 1'b1;
							end
							OP_DELETE: begin
								if (32'(index) >= 32'(total_q)) begin
									status <= STS_RANGE;
									done   <= 1'b1;
								end else begin
									state_q <= ST_SWEEP;
								end
							end
							OP_TICK: begin
								now_q   <= now_q + 32'd1;
								state_q <= ST_SWEEP;
							end
							default: begin
								done <= 1'b1;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (issue) begin
						rd_ptr_q <= rd_ptr_q + CW'(1);
					end
					if (vld_s1 && ev.hit) begin
						verdict       <= rdata.action;
						matched       <= 1'b1;
						rule_position <= 5'(pos_s1);
						hit_total     <= hits_new;
						done          <= 1'b1;
						vld_s1        <= 1'b0;
						state_q       <= ST_IDLE;
					end else if (!vld_s1 && !issue) begin
						verdict <= req_q.direction ? def_out_q : def_in_q;
						done    <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_SHIFT: begin
					if (issue) begin
						rd_ptr_q <= rd_dec;
					end
					if (!vld_s1 && (rd_ptr_q == CW'(0))) begin
						total_q   <= total_q + CW'(1);
						occupancy <= 6'(total_q + CW'(1));
						done      <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				ST_SWEEP: begin
					if (issue) begin
						rd_ptr_q <= rd_ptr_q + CW'(1);
					end
					if (vld_s1 && !drop) begin
						wr_ptr_q <= wr_ptr_q + CW'(1);
					end
					if (!vld_s1 && !issue) begin
						total_q   <= wr_ptr_q;
						occupancy <= 6'(wr_ptr_q);
						done      <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`CHK_IMPL(a_done_idle, done, !busy, "A result was issued while the table walk is still running.")
	`CHK_IMPL(a_total_bound, 1'b1, 32'(total_q) <= 32'(MAX_RULES),
		"The rule count exceeds the table depth.")
	`CHK_NEXT(a_accept_progress, start && !busy, busy || done,
		"An accepted request neither started a walk nor produced a result.")

endmodule
